// ----- design/mmc3_pkg.sv -----
// Shared types, codes and constants for the MMC3 bank mapper.
`default_nettype none
package mmc3_pkg;

  // Item kinds
  localparam logic [2:0] OP_CPU_WRITE     = 3'd0;
  localparam logic [2:0] OP_SCANLINE      = 3'd1;
  localparam logic [2:0] OP_LOW_READ      = 3'd2;
  localparam logic [2:0] OP_CPU_TRANSLATE = 3'd3;
  localparam logic [2:0] OP_PPU_TRANSLATE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_BANK_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CHR_ROM_PRESENT  = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN      = 2'd2;
  localparam logic [1:0] CFG_SECURITY_VARIANT = 2'd3;

  // Security variants
  localparam logic [1:0] SEC_NONE    = 2'd0;
  localparam logic [1:0] SEC_TABLE   = 2'd1;
  localparam logic [1:0] SEC_COUNTER = 2'd2;

  // CPU register decode (addr & REG_DECODE_MASK)
  localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRRORING   = 16'hA000;
  localparam logic [15:0] REG_RAM_ENABLE  = 16'hA001;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

  localparam logic [15:0] SEC_RESET_ADDR = 16'h5E00;
  localparam logic [15:0] SEC_DATA_ADDR  = 16'h5E01;
  localparam logic [7:0]  SEC_COUNTER_MATCH = 8'h09;
  localparam logic [7:0]  SEC_COUNTER_HIT   = 8'h6F;
  localparam logic [7:0]  SEC_COUNTER_MISS  = 8'hB4;
  localparam logic [8:0]  LAST_VISIBLE_LINE = 9'd239;

  localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd32;

  typedef logic [7:0] bank_t;

  // CHR bank register reset values R0..R5 with character ROM present, all zero without it
  function automatic bank_t chr_default(input logic [2:0] idx, input logic rom_present);
    bank_t v;
    unique case (idx)
      3'd0: v = 8'd0;
      3'd1: v = 8'd2;
      3'd2: v = 8'd4;
      3'd3: v = 8'd5;
      3'd4: v = 8'd6;
      3'd5: v = 8'd7;
      default: v = 8'd0;
    endcase
    return rom_present ? v : 8'd0;
  endfunction

  // Table-based security response sequence
  function automatic logic [7:0] sec_table(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'hff; 5'd1:  v = 8'hbf; 5'd2:  v = 8'hb7; 5'd3:  v = 8'h97;
      5'd4:  v = 8'h97; 5'd5:  v = 8'h17; 5'd6:  v = 8'h57; 5'd7:  v = 8'h4f;
      5'd8:  v = 8'h6f; 5'd9:  v = 8'h6b; 5'd10: v = 8'heb; 5'd11: v = 8'ha9;
      5'd12: v = 8'hb1; 5'd13: v = 8'h90; 5'd14: v = 8'h94; 5'd15: v = 8'h14;
      5'd16: v = 8'h56; 5'd17: v = 8'h4e; 5'd18: v = 8'h6f; 5'd19: v = 8'h6b;
      5'd20: v = 8'heb; 5'd21: v = 8'ha9; 5'd22: v = 8'hb1; 5'd23: v = 8'h90;
      5'd24: v = 8'hd4; 5'd25: v = 8'h5c; 5'd26: v = 8'h3e; 5'd27: v = 8'h26;
      5'd28: v = 8'h87; 5'd29: v = 8'h83; 5'd30: v = 8'h13;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/mmc3_bank_and_scanline_irq.sv -----
// MMC3-style bank mapper and scanline IRQ counter, top level.
//
// Items enter on the item channel (item_valid / item_stall): op selects a
// CPU register write, a scanline tick, a low-area read, or a CPU / PPU
// address translation. Every item yields exactly one result on the result
// channel (result_valid / result_stall) carrying read_data, bank, and the
// irq_line and mirror_horizontal levels after the item.
// Mapper state and the result register both load at the edge that accepts
// the item. Throughput is one item per cycle while item_stall is low; the
// single result register decides it.
// item_stall is high only while a result is held and result_stall is high,
// so a stalled receiver holds back exactly one item.
// Configuration writes (cfg_valid / cfg_ready) are always taken; writing
// chr_rom_present reloads the CHR bank registers R0..R5.
// rst (synchronous) restores configuration and mapper state to their
// power-on values and empties the result register.
`default_nettype none
module mmc3_bank_and_scanline_irq (
  input  wire logic       clk,
  input  wire logic       rst,
  // item channel
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [2:0] op,
  input  wire logic [15:0] addr,
  input  wire logic [7:0] data,
  input  wire logic signed [9:0] line,
  input  wire logic       rendering_on,
  // result channel
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      read_data,
  output mmc3_pkg::bank_t bank,
  output logic            irq_line,
  output logic            mirror_horizontal,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  import mmc3_pkg::*;

  // configuration
  logic [8:0] prg_bank_count;
  logic       four_screen;
  logic [1:0] security_variant;

  // mapper state
  logic [7:0] bank_select, bank_select_next;
  bank_t      bank_regs [8];
  bank_t      bank_regs_next [8];
  logic [7:0] irq_latch_value, irq_latch_value_next;
  logic [7:0] irq_count, irq_count_next;
  logic       irq_reload_flag, irq_reload_flag_next;
  logic       irq_enable_flag, irq_enable_flag_next;
  logic       irq_level, irq_level_next;
  logic       mirror_h, mirror_h_next;
  logic [7:0] security_index, security_index_next;

  logic       accept;
  logic       cfg_write;
  logic [7:0] rd_next;
  bank_t      bank_next;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;

  // item decode and state update
  always_comb begin
    logic [15:0] reg_addr;
    logic [2:0]  sel;
    logic        line_visible;
    logic        sec_on;
    logic [7:0]  last_bank;
    logic [7:0]  second_bank;
    logic        prg_swap;
    logic [2:0]  chr_slot;

    bank_select_next     = bank_select;
    bank_regs_next       = bank_regs;
    irq_latch_value_next = irq_latch_value;
    irq_count_next       = irq_count;
    irq_reload_flag_next = irq_reload_flag;
    irq_enable_flag_next = irq_enable_flag;
    irq_level_next       = irq_level;
    mirror_h_next        = mirror_h;
    security_index_next  = security_index;
    rd_next              = 8'd0;
    bank_next            = 8'd0;

    reg_addr     = addr & REG_DECODE_MASK;
    sel          = bank_select[2:0];
    line_visible = !line[9] && (line[8:0] <= LAST_VISIBLE_LINE);
    sec_on       = (security_variant == SEC_TABLE) || (security_variant == SEC_COUNTER);
    last_bank    = prg_bank_count[7:0] - 8'd1;
    second_bank  = prg_bank_count[7:0] - 8'd2;
    prg_swap     = bank_select[6];
    chr_slot     = addr[12:10] ^ {bank_select[7], 2'b00};

    unique case (op)
      OP_CPU_WRITE: begin
        unique case (reg_addr)
          REG_BANK_SELECT: bank_select_next = data;
          REG_BANK_DATA:
            bank_regs_next[sel] = (sel[2:1] == 2'b00) ? {data[7:1], 1'b0} : data;
          REG_MIRRORING: if (!four_screen) mirror_h_next = data[0];
          REG_IRQ_LATCH: irq_latch_value_next = data;
          REG_IRQ_RELOAD: irq_reload_flag_next = 1'b1;
          REG_IRQ_DISABLE: begin
            irq_enable_flag_next = 1'b0;
            irq_level_next       = 1'b0;
          end
          REG_IRQ_ENABLE: irq_enable_flag_next = 1'b1;
          default: ;  // RAM enable and unmapped writes do nothing
        endcase
      end
      OP_SCANLINE: begin
        if (line_visible && rendering_on) begin
          if (irq_count == 8'd0 || irq_reload_flag) begin
            irq_count_next       = irq_latch_value;
            irq_reload_flag_next = 1'b0;
          end else begin
            irq_count_next = irq_count - 8'd1;
          end
          if (irq_count_next == 8'd0 && irq_enable_flag) irq_level_next = 1'b1;
        end
      end
      OP_LOW_READ: begin
        priority if (sec_on && addr == SEC_RESET_ADDR) begin
          security_index_next = 8'd0;
          rd_next = (security_variant == SEC_TABLE) ? 8'h00 : 8'hFF;
        end else if (sec_on && addr == SEC_DATA_ADDR) begin
          if (security_variant == SEC_TABLE)
            rd_next = sec_table(security_index[4:0]);
          else
            rd_next = (security_index == SEC_COUNTER_MATCH) ? SEC_COUNTER_HIT
                                                            : SEC_COUNTER_MISS;
          security_index_next = security_index + 8'd1;
        end else begin
          rd_next = addr[15:8];  // open bus
        end
      end
      OP_CPU_TRANSLATE: begin
        if (addr[15]) begin
          unique case (addr[14:13])
            2'd0: bank_next = prg_swap ? second_bank : bank_regs[6];
            2'd1: bank_next = bank_regs[7];
            2'd2: bank_next = prg_swap ? bank_regs[6] : second_bank;
            default: bank_next = last_bank;
          endcase
        end
      end
      OP_PPU_TRANSLATE: begin
        if (addr[15:13] == 3'd0) begin
          unique case (chr_slot)
            3'd0: bank_next = bank_regs[0];
            3'd1: bank_next = bank_regs[0] + 8'd1;
            3'd2: bank_next = bank_regs[1];
            3'd3: bank_next = bank_regs[1] + 8'd1;
            3'd4: bank_next = bank_regs[2];
            3'd5: bank_next = bank_regs[3];
            3'd6: bank_next = bank_regs[4];
            default: bank_next = bank_regs[5];
          endcase
        end
      end
      default: ;
    endcase
  end

  // configuration and mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count   <= PRG_BANK_COUNT_RESET;
      four_screen      <= 1'b0;
      security_variant <= SEC_NONE;
      bank_select      <= 8'd0;
      for (int i = 0; i < 6; i++) bank_regs[i] <= chr_default(3'(i), 1'b1);
      bank_regs[6]     <= 8'd0;
      bank_regs[7]     <= 8'd1;
      irq_latch_value  <= 8'd0;
      irq_count        <= 8'd0;
      irq_reload_flag  <= 1'b0;
      irq_enable_flag  <= 1'b0;
      irq_level        <= 1'b0;
      mirror_h         <= 1'b0;
      security_index   <= 8'd0;
    end else begin
      // the user is to write configuration only while no item is in flight; not enforced here
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
          CFG_CHR_ROM_PRESENT: begin
            for (int i = 0; i < 6; i++) bank_regs[i] <= chr_default(3'(i), cfg_data[0]);
          end
          CFG_FOUR_SCREEN: four_screen <= cfg_data[0];
          default: security_variant <= cfg_data[1:0];
        endcase
      end
      if (accept) begin
        bank_select     <= bank_select_next;
        bank_regs       <= bank_regs_next;
        irq_latch_value <= irq_latch_value_next;
        irq_count       <= irq_count_next;
        irq_reload_flag <= irq_reload_flag_next;
        irq_enable_flag <= irq_enable_flag_next;
        irq_level       <= irq_level_next;
        mirror_h        <= mirror_h_next;
        security_index  <= security_index_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data         <= rd_next;
      bank              <= bank_next;
      irq_line          <= irq_level_next;
      mirror_horizontal <= mirror_h_next;
    end
  end

endmodule
`default_nettype wire

// ----- sim/mmc3_mapper_checker.sv -----
// Mapper scoreboard: watches config, item and result channels, predicts and compares.
`timescale 1ns / 1ps
module mmc3_mapper_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [2:0]        op,
  input  logic [15:0]       addr,
  input  logic [7:0]        data,
  input  logic signed [9:0] line,
  input  logic              rendering_on,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [7:0]        read_data,
  input  mmc3_pkg::bank_t   bank,
  input  logic              irq_line,
  input  logic              mirror_horizontal,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                results_checked,
  output int                irq_high_seen
);
  import mmc3_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    bank_t      bank;
    logic       irq_line;
    logic       mirror_horizontal;
  } mapper_result_t;

  // security answer sequence, entry 0 in the top byte
  localparam logic [255:0] SEC_SEQ = {
    8'hff, 8'hbf, 8'hb7, 8'h97, 8'h97, 8'h17, 8'h57, 8'h4f,
    8'h6f, 8'h6b, 8'heb, 8'ha9, 8'hb1, 8'h90, 8'h94, 8'h14,
    8'h56, 8'h4e, 8'h6f, 8'h6b, 8'heb, 8'ha9, 8'hb1, 8'h90,
    8'hd4, 8'h5c, 8'h3e, 8'h26, 8'h87, 8'h83, 8'h13, 8'h00
  };
  // R0..R5 power-on values with character ROM, R0 in the top byte
  localparam logic [47:0] CHR_INIT = {8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};

  logic [8:0] prg_count;
  logic       chr_rom;
  logic       four_scr;
  logic [1:0] sec_mode;

  logic [7:0] bank_sel;
  bank_t      bank_r [8];
  logic [7:0] cnt_latch;
  logic [7:0] irq_cnt;
  logic       reload_pend;
  logic       irq_en;
  logic       irq_lvl;
  logic       mir_h;
  logic [7:0] sec_idx;

  mapper_result_t expected_results [$];

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    results_checked = 0;
    irq_high_seen   = 0;
  end

  task automatic reload_chr_banks();
    for (int i = 0; i < 6; i++)
      bank_r[i] = chr_rom ? CHR_INIT[8*(5-i) +: 8] : 8'd0;
  endtask

  task automatic reset_mapper();
    prg_count   = PRG_BANK_COUNT_RESET;
    chr_rom     = 1'b1;
    four_scr    = 1'b0;
    sec_mode    = SEC_NONE;
    bank_sel    = 8'd0;
    reload_chr_banks();
    bank_r[6]   = 8'd0;
    bank_r[7]   = 8'd1;
    cnt_latch   = 8'd0;
    irq_cnt     = 8'd0;
    reload_pend = 1'b0;
    irq_en      = 1'b0;
    irq_lvl     = 1'b0;
    mir_h       = 1'b0;
    sec_idx     = 8'd0;
  endtask

  task automatic write_mapper_cfg(input logic [1:0] idx, input logic [8:0] val);
    case (idx)
      CFG_PRG_BANK_COUNT:   prg_count = val;
      CFG_CHR_ROM_PRESENT: begin
        chr_rom = val[0];
        reload_chr_banks();
      end
      CFG_FOUR_SCREEN:      four_scr = val[0];
      CFG_SECURITY_VARIANT: sec_mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic map_item(input logic [2:0] it_op, input logic [15:0] it_addr,
                          input logic [7:0] it_data, input logic signed [9:0] it_line,
                          input logic it_rend, output mapper_result_t res);
    int         ln;
    logic [2:0] sel;
    logic [2:0] slot;
    logic [7:0] last_bank;
    logic [7:0] second_bank;
    ln = it_line;
    res = '0;
    case (it_op)
      OP_CPU_WRITE: begin
        case (it_addr & REG_DECODE_MASK)
          REG_BANK_SELECT: bank_sel = it_data;
          REG_BANK_DATA: begin
            sel = bank_sel[2:0];
            bank_r[sel] = (sel < 3'd2) ? (it_data & 8'hFE) : it_data;
          end
          REG_MIRRORING: if (!four_scr) mir_h = it_data[0];
          REG_IRQ_LATCH:   cnt_latch = it_data;
          REG_IRQ_RELOAD:  reload_pend = 1'b1;
          REG_IRQ_DISABLE: begin
            irq_en  = 1'b0;
            irq_lvl = 1'b0;
          end
          REG_IRQ_ENABLE:  irq_en = 1'b1;
          default: ;
        endcase
      end
      OP_SCANLINE: begin
        if (ln >= 0 && ln <= int'(LAST_VISIBLE_LINE) && it_rend) begin
          if (irq_cnt == 8'd0 || reload_pend) begin
            irq_cnt     = cnt_latch;
            reload_pend = 1'b0;
          end else begin
            irq_cnt = irq_cnt - 8'd1;
          end
          if (irq_cnt == 8'd0 && irq_en) irq_lvl = 1'b1;
        end
      end
      OP_LOW_READ: begin
        res.read_data = it_addr[15:8];
        if (sec_mode == SEC_TABLE || sec_mode == SEC_COUNTER) begin
          if (it_addr == SEC_RESET_ADDR) begin
            sec_idx = 8'd0;
            res.read_data = (sec_mode == SEC_TABLE) ? 8'h00 : 8'hFF;
          end else if (it_addr == SEC_DATA_ADDR) begin
            if (sec_mode == SEC_TABLE)
              res.read_data = SEC_SEQ[8*(31 - sec_idx[4:0]) +: 8];
            else
              res.read_data = (sec_idx == SEC_COUNTER_MATCH) ? SEC_COUNTER_HIT
                                                             : SEC_COUNTER_MISS;
            sec_idx = sec_idx + 8'd1;
          end
        end
      end
      OP_CPU_TRANSLATE: begin
        last_bank   = prg_count[7:0] - 8'd1;
        second_bank = prg_count[7:0] - 8'd2;
        if (it_addr >= 16'h8000) begin
          case (it_addr[14:13])
            2'd0:    res.bank = bank_sel[6] ? second_bank : bank_r[6];
            2'd1:    res.bank = bank_r[7];
            2'd2:    res.bank = bank_sel[6] ? bank_r[6] : second_bank;
            default: res.bank = last_bank;
          endcase
        end
      end
      OP_PPU_TRANSLATE: begin
        if (it_addr < 16'h2000) begin
          slot = it_addr[12:10];
          if (bank_sel[7]) slot = slot ^ 3'd4;
          case (slot)
            3'd0:    res.bank = bank_r[0];
            3'd1:    res.bank = bank_r[0] + 8'd1;
            3'd2:    res.bank = bank_r[1];
            3'd3:    res.bank = bank_r[1] + 8'd1;
            default: res.bank = bank_r[slot - 3'd2];
          endcase
        end
      end
      default: ;
    endcase
    res.irq_line          = irq_lvl;
    res.mirror_horizontal = mir_h;
  endtask

  // Inputs change only at rising edges, so the values at the falling edge are
  // the ones the next rising edge acts on.
  always @(negedge clk) begin
    mapper_result_t exp_r;
    mapper_result_t new_r;
    if (rst) begin
      reset_mapper();
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (irq_line === 1'b1) irq_high_seen++;
          if (read_data !== exp_r.read_data) begin
            $error("read_data: expected %02h, got %02h", exp_r.read_data, read_data);
            fail_count++;
          end
          if (bank !== exp_r.bank) begin
            $error("bank: expected %02h, got %02h", exp_r.bank, bank);
            fail_count++;
          end
          if (irq_line !== exp_r.irq_line) begin
            $error("irq_line: expected %0b, got %0b", exp_r.irq_line, irq_line);
            fail_count++;
          end
          if (mirror_horizontal !== exp_r.mirror_horizontal) begin
            $error("mirror_horizontal: expected %0b, got %0b",
                   exp_r.mirror_horizontal, mirror_horizontal);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) write_mapper_cfg(cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        map_item(op, addr, data, line, rendering_on, new_r);
        expected_results.push_back(new_r);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: drives mapper items and config writes, paces both channels, reports.
`timescale 1ns / 1ps
module tb_top;
  import mmc3_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         ITEMS_PER_PHASE = 150;
  localparam int         RANDOM_PHASES   = 8;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam logic [1:0] SEC_UNUSED      = 2'd3;

  typedef struct packed {
    logic [2:0]        op;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic signed [9:0] line;
    logic              rendering_on;
  } item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [2:0]        op = OP_CPU_WRITE;
  logic [15:0]       addr = 16'd0;
  logic [7:0]        data = 8'd0;
  logic signed [9:0] line = 10'sd0;
  logic              rendering_on = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [7:0]        read_data;
  bank_t             bank;
  logic              irq_line;
  logic              mirror_horizontal;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_PRG_BANK_COUNT;
  logic [8:0]        cfg_data = 9'd0;

  int fail_count;
  int pending_count;
  int results_checked;
  int irq_high_seen;
  int cycle_count = 0;
  int items_sent = 0;
  int settings_used = 0;

  mmc3_bank_and_scanline_irq u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .addr(addr), .data(data), .line(line), .rendering_on(rendering_on),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_data(read_data), .bank(bank), .irq_line(irq_line),
    .mirror_horizontal(mirror_horizontal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mmc3_mapper_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .addr(addr), .data(data), .line(line), .rendering_on(rendering_on),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_data(read_data), .bank(bank), .irq_line(irq_line),
    .mirror_horizontal(mirror_horizontal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .results_checked(results_checked), .irq_high_seen(irq_high_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic item_t mk_item(input logic [2:0] k, input logic [15:0] a,
                                    input logic [7:0] d, input int ln, input logic r);
    item_t it;
    it.op = k;
    it.addr = a;
    it.data = d;
    it.line = 10'(ln);
    it.rendering_on = r;
    return it;
  endfunction

  // Mostly well-formed register traffic and visible ticks so the IRQ counter
  // and the security sequences get exercised; the rest is raw noise.
  function automatic item_t random_item();
    item_t       it;
    int          pick;
    logic [15:0] reg_code;
    it.op = OP_CPU_WRITE;
    it.addr = 16'($urandom);
    it.data = 8'($urandom);
    it.line = 10'($urandom_range(0, 262) - 1);
    it.rendering_on = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 7))
          0:       reg_code = REG_BANK_SELECT;
          1:       reg_code = REG_BANK_DATA;
          2:       reg_code = REG_MIRRORING;
          3:       reg_code = REG_RAM_ENABLE;
          4:       reg_code = REG_IRQ_LATCH;
          5:       reg_code = REG_IRQ_RELOAD;
          6:       reg_code = REG_IRQ_DISABLE;
          default: reg_code = REG_IRQ_ENABLE;
        endcase
        it.addr = (it.addr & ~REG_DECODE_MASK) | reg_code;
        if (reg_code == REG_IRQ_LATCH && $urandom_range(0, 3) != 0)
          it.data = 8'($urandom_range(0, 6));
      end
    end else if (pick < 65) begin
      it.op = OP_SCANLINE;
      if ($urandom_range(0, 7) != 0) begin
        it.line = 10'($urandom_range(0, 239));
        it.rendering_on = 1'b1;
      end
    end else if (pick < 77) begin
      it.op = OP_LOW_READ;
      case ($urandom_range(0, 7))
        0:          it.addr = SEC_RESET_ADDR;
        1, 2, 3, 4, 5: it.addr = SEC_DATA_ADDR;
        default: ;
      endcase
    end else if (pick < 87) begin
      it.op = OP_CPU_TRANSLATE;
      if ($urandom_range(0, 4) != 0) it.addr[15] = 1'b1;
    end else if (pick < 97) begin
      it.op = OP_PPU_TRANSLATE;
      if ($urandom_range(0, 4) != 0) it.addr[15:13] = 3'd0;
    end else begin
      it.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that takes the item.
  task automatic send_item(input item_t it);
    bit taken;
    item_valid   <= 1'b1;
    op           <= it.op;
    addr         <= it.addr;
    data         <= it.data;
    line         <= it.line;
    rendering_on <= it.rendering_on;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [8:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic program_mapper(input logic [8:0] prg, input logic chr, input logic four,
                                input logic [1:0] sec);
    drain_results();
    repeat (4) @(posedge clk);
    write_cfg(CFG_PRG_BANK_COUNT, prg);
    write_cfg(CFG_CHR_ROM_PRESENT, {8'd0, chr});
    write_cfg(CFG_FOUR_SCREEN, {8'd0, four});
    write_cfg(CFG_SECURITY_VARIANT, {7'd0, sec});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_directed();
    item_t seq [$];
    seq.push_back(mk_item(OP_CPU_TRANSLATE, 16'h7FFF, 8'h00, 0, 1'b0));   // below PRG space
    seq.push_back(mk_item(OP_CPU_TRANSLATE, 16'hFFFF, 8'hFF, 0, 1'b0));   // fixed last bank
    seq.push_back(mk_item(OP_PPU_TRANSLATE, 16'h2000, 8'h00, 0, 1'b0));   // above CHR space
    seq.push_back(mk_item(OP_PPU_TRANSLATE, 16'h1FFF, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_BANK_SELECT, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_BANK_DATA, 8'hFF, 0, 1'b0));  // R0 drops bit 0
    seq.push_back(mk_item(OP_CPU_WRITE, REG_BANK_SELECT, 8'hC1, 0, 1'b0)); // both swaps
    seq.push_back(mk_item(OP_CPU_WRITE, 16'h9FFF, 8'h01, 0, 1'b0));       // R1 via mirror addr
    seq.push_back(mk_item(OP_PPU_TRANSLATE, 16'h0400, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_TRANSLATE, 16'h8000, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_MIRRORING, 8'h01, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_RAM_ENABLE, 8'hFF, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_IRQ_LATCH, 8'h01, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_IRQ_RELOAD, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_CPU_WRITE, REG_IRQ_ENABLE, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, -1, 1'b1));       // pre-render line
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, 0, 1'b1));        // reload
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, 240, 1'b1));      // past visible
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, 239, 1'b0));      // rendering off
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, 239, 1'b1));      // hits zero
    seq.push_back(mk_item(OP_CPU_WRITE, REG_IRQ_DISABLE, 8'h00, 0, 1'b0)); // drops irq
    seq.push_back(mk_item(OP_LAST_UNUSED, 16'hFFFF, 8'hFF, 261, 1'b1));
    seq.push_back(mk_item(OP_LOW_READ, SEC_RESET_ADDR, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_LOW_READ, SEC_DATA_ADDR, 8'h00, 0, 1'b0));
    seq.push_back(mk_item(OP_LOW_READ, 16'h4123, 8'h00, 0, 1'b0));       // open bus
    seq.push_back(mk_item(OP_SCANLINE, 16'h0000, 8'h00, 261, 1'b1));
    foreach (seq[i]) send_item(seq[i]);
  endtask

  task automatic run_random(input int count, input bit with_pause);
    int sent;
    int burst;
    int gap;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item(random_item());
        sent++;
      end
      if (with_pause && !paused && sent >= count / 2) begin
        drain_results();
        paused = 1;
      end else begin
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Receiver pacing: segments of differing stall density plus long hold-offs.
  initial begin : result_pacing
    int seg_no;
    int seg_len;
    int mode;
    int hold;
    bit toggle;
    seg_no = 0;
    toggle = 0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 80);
      if (seg_no == 6 || $urandom_range(0, 19) == 0) begin
        hold = $urandom_range(60, 120);
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      repeat (seg_len) begin
        toggle = !toggle;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 9) < 7);
          default: result_stall <= toggle;
        endcase
        @(posedge clk);
      end
      seg_no++;
    end
  end

  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mmc3_bank_and_scanline_irq verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_mapper(9'd256, 1'b1, 1'b0, SEC_TABLE);
    run_directed();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       program_mapper(9'd2, 1'b0, 1'b1, SEC_COUNTER);
        1:       program_mapper(9'd255, 1'b1, 1'b0, SEC_TABLE);
        2:       program_mapper(9'd3, 1'b1, 1'b1, SEC_UNUSED);
        3:       program_mapper(9'd32, 1'b0, 1'b0, SEC_NONE);
        default: program_mapper(9'($urandom_range(2, 256)), 1'($urandom), 1'($urandom),
                                2'($urandom_range(0, 3)));
      endcase
      run_random(ITEMS_PER_PHASE, p == 1);
    end
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d items over %0d mapper settings (writes, ticks, reads, translates).",
             items_sent, settings_used);
    $display("Checked %0d results, %0d of them with the IRQ line high.",
             results_checked, irq_high_seen);
    if (fail_count == 0) begin
      $display("mmc3_bank_and_scanline_irq verification clean");
    end else begin
      $display("mmc3_bank_and_scanline_irq verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mmc3_pkg.sv
design/mmc3_bank_and_scanline_irq.sv
sim/mmc3_mapper_checker.sv
sim/tb_top.sv
